// ===== sv/positional_list_insert_remove_core_assert.svh =====
// Assertion macros for the positional list core.
// Depends on signals named clk and arst_n in the including module.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLIR_AST_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLIR_AST_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) else $error(msg);

`endif

// ===== sv/plir_pkg.sv =====
// Shared types and codes for the positional list core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package plir_pkg;

	localparam int REQ_W  = 3;
	localparam int POS_W  = 9;
	localparam int IKEY_W = 16;
	localparam int OKEY_W = 16;
	localparam int ERR_W  = 2;
	localparam int TOT_W  = 9;

	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_REM_POS   = 3'd5;

	localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_POS  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL = 2'd2;

	typedef struct packed {
		logic ins;
		logic rem;
		logic tap_en;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/plir_cell.sv =====
// One storage cell of the list: holds a key and shifts with its neighbors.
// Depends on plir_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module plir_cell
	import plir_pkg::*;
#(
	parameter int IDX = 0,
	parameter int AW  = 9,
	parameter int KW  = 16
) (
	input  wire logic          clk,
	input  wire cell_ctl_t     ctl,
	input  wire logic [AW-1:0] pos,
	input  wire logic [KW-1:0] new_key,
	input  wire logic [KW-1:0] left_key,
	input  wire logic [KW-1:0] right_key,
	output logic      [KW-1:0] key_q,
	output logic      [KW-1:0] tap_s2
);

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic at_pos;
	logic past_pos;

	assign at_pos   = (MY_IDX == pos);
	assign past_pos = (MY_IDX > pos);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_pos) begin
				key_q <= new_key;
			end else if (past_pos) begin
				key_q <= left_key;
			end
		end else if (ctl.rem) begin
			if (at_pos || past_pos) begin
				key_q <= right_key;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tap_en) begin
			tap_s2 <= (ctl.rem && at_pos) ? key_q : '0;
		end
	end

endmodule

`default_nettype wire

// ===== sv/plir_or_tree.sv =====
// Registered two-level OR tree that gathers the one-hot cell taps.
// Depends on plir_pkg; fed by the plir_cell row.
`timescale 1ns / 1ps
`default_nettype none

module plir_or_tree
	import plir_pkg::*;
#(
	parameter int N = 256,
	parameter int W = 16
) (
	input  wire logic                clk,
	input  wire logic                load,
	input  wire logic [N-1:0][W-1:0] taps,
	output logic      [W-1:0]        result
);

	localparam int GRP = 64;
	localparam int NG  = (N + GRP - 1) / GRP;

	logic [NG-1:0][W-1:0] grp_s3;

	for (genvar g = 0; g < NG; g++) begin : g_grp
		logic [W-1:0] acc;

		always_comb begin
			acc = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < N) begin
					acc = acc | taps[g * GRP + j];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (load) begin
				grp_s3[g] <= acc;
			end
		end
	end

	always_comb begin
		result = '0;
		for (int g = 0; g < NG; g++) begin
			result = result | grp_s3[g];
		end
	end

endmodule

`default_nettype wire

// ===== sv/positional_list_insert_remove_core.sv =====
// Positional list core: a row of key cells with insert and remove at any index.
// Depends on plir_pkg, plir_cell, plir_or_tree and the assertion header.
//
// Usage: the input channel (in_valid, in_stall) carries one request beat with
// req_type, position and item_key. The output channel (out_valid, out_stall)
// returns one beat per request with removed_key, error_code and entry_total.
// A request is executed in the cycle after it is accepted: every cell compares
// its own index with the target position and shifts toward or away from its
// neighbor in that same cycle. The removed key is then gathered through a
// registered two-level OR tree; it passes the cell tap register, the tree's
// group register and the output register in turn. One request is in flight
// at a time, so a new beat is taken only once the last one has left the tree.
// While the output register holds a result that is stalled, the next request
// is still accepted and executed, and it waits in the last tree stage.
// Reset empties the list and drops any request in flight; cell contents are
// not cleared, since entries past the count are never read.
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_insert_remove_core_assert.svh"

module positional_list_insert_remove_core
	import plir_pkg::*;
#(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [REQ_W-1:0]  req_type,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [IKEY_W-1:0] item_key,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [OKEY_W-1:0]      removed_key,
	output logic [ERR_W-1:0]       error_code,
	output logic [TOT_W-1:0]       entry_total
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CW > POS_W) ? CW : POS_W;

	logic                 v_s1_q, v_s2_q, v_s3_q;
	logic [REQ_W-1:0]     req_q;
	logic [AW-1:0]        pos_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CW-1:0]        count_q;

	logic [ERR_W-1:0] err_s2, err_s3;
	logic [CW-1:0]    total_s2, total_s3;

	logic                 is_ins, is_rem;
	logic [AW-1:0]        tpos, cnt_ext;
	logic [ERR_W-1:0]     err;
	logic                 ins_ok, rem_ok;
	cell_ctl_t            ctl;
	logic                 out_free, s3_move;
	logic [KEY_WIDTH+IKEY_W-1:0] in_key_ext;
	logic [KEY_WIDTH+OKEY_W-1:0] out_key_ext;
	logic [CW+TOT_W-1:0]  tot_ext;
	logic [KEY_WIDTH-1:0] tree_out;

	logic [CAPACITY-1:0][KEY_WIDTH-1:0] cell_key;
	logic [CAPACITY-1:0][KEY_WIDTH-1:0] cell_tap;

	assign in_key_ext = {{KEY_WIDTH{1'b0}}, item_key};
	assign in_stall   = v_s1_q | v_s2_q | v_s3_q;
	assign out_free   = !out_valid || !out_stall;
	assign s3_move    = v_s3_q && out_free;
	assign cnt_ext    = AW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else begin
			v_s1_q <= in_valid && !in_stall;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q || (v_s3_q && !out_free);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_q <= req_type;
			pos_q <= AW'(position);
			key_q <= in_key_ext[KEY_WIDTH-1:0];
		end
	end

	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		tpos   = '0;
		unique case (req_q)
			REQ_INS_FRONT: begin
				is_ins = 1'b1;
			end
			REQ_INS_BACK: begin
				is_ins = 1'b1;
				tpos   = cnt_ext;
			end
			REQ_INS_POS: begin
				is_ins = 1'b1;
				tpos   = pos_q;
			end
			REQ_REM_FRONT: begin
				is_rem = 1'b1;
			end
			REQ_REM_BACK: begin
				is_rem = 1'b1;
				tpos   = cnt_ext - AW'(1);
			end
			REQ_REM_POS: begin
				is_rem = 1'b1;
				tpos   = pos_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		err = ERR_OK;
		if (is_ins) begin
			if (tpos > cnt_ext) begin
				err = ERR_POS;
			end else if (count_q == CW'(CAPACITY)) begin
				err = ERR_FULL;
			end
		end else if (is_rem) begin
			if (count_q == '0 || tpos >= cnt_ext) begin
				err = ERR_POS;
			end
		end
	end

	assign ins_ok     = v_s1_q && is_ins && (err == ERR_OK);
	assign rem_ok     = v_s1_q && is_rem && (err == ERR_OK);
	assign ctl.ins    = ins_ok;
	assign ctl.rem    = rem_ok;
	assign ctl.tap_en = v_s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins_ok) begin
			count_q <= count_q + CW'(1);
		end else if (rem_ok) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1_q) begin
			err_s2   <= err;
			total_s2 <= ins_ok ? count_q + CW'(1) : (rem_ok ? count_q - CW'(1) : count_q);
		end
		if (v_s2_q) begin
			err_s3   <= err_s2;
			total_s3 <= total_s2;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_WIDTH-1:0] left_k, right_k;

		if (i == 0) begin : g_first
			assign left_k = '0;
		end else begin : g_left
			assign left_k = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_k = '0;
		end else begin : g_right
			assign right_k = cell_key[i+1];
		end

		plir_cell #(
			.IDX (i),
			.AW  (AW),
			.KW  (KEY_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.pos       (tpos),
			.new_key   (key_q),
			.left_key  (left_k),
			.right_key (right_k),
			.key_q     (cell_key[i]),
			.tap_s2    (cell_tap[i])
		);
	end

	plir_or_tree #(
		.N (CAPACITY),
		.W (KEY_WIDTH)
	) u_tree (
		.clk    (clk),
		.load   (v_s2_q),
		.taps   (cell_tap),
		.result (tree_out)
	);

	assign out_key_ext = {{OKEY_W{1'b0}}, tree_out};
	assign tot_ext     = {{TOT_W{1'b0}}, total_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= v_s3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_move) begin
			removed_key <= out_key_ext[OKEY_W-1:0];
			error_code  <= err_s3;
			entry_total <= tot_ext[TOT_W-1:0];
		end
	end

	`PLIR_AST_NOW(a_one_in_flight, 1'b1, $onehot0({v_s1_q, v_s2_q, v_s3_q}),
		"more than one request in flight")
	`PLIR_AST_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY),
		"entry count exceeds capacity")
	`PLIR_AST_NOW(a_full_err, v_s1_q && err == ERR_FULL, count_q == CW'(CAPACITY),
		"full error flagged on a list that is not full")
	`PLIR_AST_NEXT(a_rem_count, rem_ok, count_q == $past(count_q) - CW'(1),
		"successful removal did not drop the count by one")

endmodule

`default_nettype wire
